// ----- hdl/assert_macros.svh -----
// assertion helpers, sampled on the rising edge of i_clk, muted while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that must hold at every edge
`define CPT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// a condition that must hold at the edge after a trigger
`define CPT_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ----- hdl/cpt_pkg.sv -----
package cpt_pkg;

    localparam int DEF_MAX_CIRCLES = 64;

    localparam int POS_W = 12;
    localparam int RAD_W = 11;
    localparam int CNT_W = 7;
    localparam int FLD_W = 13;

    // commands
    localparam logic [1:0] CMD_PLACE  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_PLACED  = 3'd0;
    localparam logic [2:0] STAT_BORDER  = 3'd1;
    localparam logic [2:0] STAT_OVERLAP = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_REMOVED = 3'd4;
    localparam logic [2:0] STAT_MISS    = 3'd5;

    // register word indexes
    localparam logic [1:0] REG_CENTER_X     = 2'd0;
    localparam logic [1:0] REG_CENTER_Y     = 2'd1;
    localparam logic [1:0] REG_FIELD_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FIELD_HEIGHT = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [RAD_W-1:0] r;
    } t_circle;

    typedef struct packed {
        logic [1:0]       command;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [RAD_W-1:0] radius;
    } t_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] removed_x;
        logic [POS_W-1:0] removed_y;
        logic [RAD_W-1:0] removed_radius;
        logic [CNT_W-1:0] stored_count;
    } t_out;

    typedef struct packed {
        logic sq_en;
        logic cmp_en;
        logic upd_en;
        logic remove_mode;
        logic store;
        logic shift;
    } t_cell_ctl;

endpackage

// ----- hdl/cpt_cell.sv -----
module cpt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_B = 7
) (
    input  logic                  i_clk,
    input  cpt_pkg::t_cell_ctl    i_ctl,
    input  cpt_pkg::t_circle      i_pos,
    input  logic [CNT_B-1:0]      i_count,
    input  cpt_pkg::t_circle      i_next,
    input  logic                  i_prior,
    output cpt_pkg::t_circle      o_data,
    output logic                  o_prior,
    output logic                  o_first
);

    cpt_pkg::t_circle r_data;
    logic [23:0]      r_dx2;
    logic [23:0]      r_dy2;
    logic [23:0]      r_thr2;
    logic             r_flag;

    logic               w_valid;
    logic signed [12:0] w_dx;
    logic signed [12:0] w_dy;
    logic signed [25:0] w_dx_sq;
    logic signed [25:0] w_dy_sq;
    logic [11:0]        w_thr;
    logic [23:0]        w_thr_sq;
    logic [24:0]        w_dist;
    logic [24:0]        w_lim;
    logic               n_flag;

    assign w_valid = (CNT_B'(IDX) < i_count);

    assign w_dx     = $signed({1'b0, r_data.x}) - $signed({1'b0, i_pos.x});
    assign w_dy     = $signed({1'b0, r_data.y}) - $signed({1'b0, i_pos.y});
    assign w_dx_sq  = 26'(w_dx) * 26'(w_dx);
    assign w_dy_sq  = 26'(w_dy) * 26'(w_dy);
    // remove probes against the own radius, place against the radius sum
    assign w_thr    = i_ctl.remove_mode ? {1'b0, r_data.r}
                                        : ({1'b0, r_data.r} + {1'b0, i_pos.r});
    assign w_thr_sq = {12'd0, w_thr} * {12'd0, w_thr};

    assign w_dist = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_lim  = {1'b0, r_thr2};
    assign n_flag = w_valid && (i_ctl.remove_mode ? (w_dist < w_lim) : !(w_dist > w_lim));

    always_ff @(posedge i_clk) begin
        if (i_ctl.sq_en) begin
            r_dx2  <= w_dx_sq[23:0];
            r_dy2  <= w_dy_sq[23:0];
            r_thr2 <= w_thr_sq;
        end
        if (i_ctl.cmp_en) begin
            r_flag <= n_flag;
        end
        if (i_ctl.upd_en) begin
            if (i_ctl.store && (CNT_B'(IDX) == i_count)) begin
                r_data <= i_pos;
            end else if (i_ctl.shift && (i_prior || r_flag)) begin
                r_data <= i_next;
            end
        end
    end

    assign o_data  = r_data;
    assign o_prior = i_prior | r_flag;
    assign o_first = r_flag & ~i_prior;

endmodule

// ----- hdl/circle_placement_table_unit.sv -----
// circle placement table: holds up to MAX_CIRCLES circles in a row of cells,
// one circle per cell in insertion order. A command is taken when start is
// high and busy low; every command gives exactly one result, shown for one
// cycle with o_done high, and the receiver cannot stall it. After the accepting
// edge a command steps through S_SQ for the squared distances in every cell,
// S_CMP for the per-cell compares and the border test, and S_PICK for the
// first-hit pick through the cell chain and the table update, and the result is
// shown in the result cycle, back in S_IDLE. busy is high in S_SQ, S_CMP and
// S_PICK. A new command can be accepted at the edge that ends the
// result cycle. No clearing pass follows reset: cells beyond the stored count
// are never looked at. Field registers are written over the apb port and must
// only change while the block is idle.
`include "assert_macros.svh"

module circle_placement_table_unit #(
    parameter int MAX_CIRCLES = cpt_pkg::DEF_MAX_CIRCLES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // command side
    input  logic            start,
    output logic            busy,
    input  cpt_pkg::t_in    i_in,
    // result side
    output logic            o_done,
    output cpt_pkg::t_out   o_result,
    // apb config port
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int CW = $clog2(MAX_CIRCLES + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQ   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_PICK = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    cpt_pkg::t_in                  r_in;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_border_ok;
    logic                          r_done;
    cpt_pkg::t_out                 r_out;
    cpt_pkg::t_out                 n_out;

    logic [cpt_pkg::POS_W-1:0]     r_center_x;
    logic [cpt_pkg::POS_W-1:0]     r_center_y;
    logic [cpt_pkg::FLD_W-1:0]     r_field_w;
    logic [cpt_pkg::FLD_W-1:0]     r_field_h;

    // cell chain wiring
    cpt_pkg::t_circle              w_data  [MAX_CIRCLES];
    logic [MAX_CIRCLES-1:0]        w_first;
    logic [MAX_CIRCLES:0]          w_prior;
    cpt_pkg::t_cell_ctl            w_ctl;
    cpt_pkg::t_circle              w_pos;
    cpt_pkg::t_circle              w_hit;

    logic                          w_accept;
    logic                          w_cfg_wr;
    logic                          w_full;
    logic                          w_any;
    logic                          w_store;
    logic [CW+6:0]                 w_cnt_ext;

    // border test, all in signed 15 bit
    logic signed [14:0]            w_cx;
    logic signed [14:0]            w_cy;
    logic signed [14:0]            w_hw;
    logic signed [14:0]            w_hh;
    logic signed [14:0]            w_r;
    logic signed [14:0]            w_px;
    logic signed [14:0]            w_py;
    logic                          n_border_ok;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // ---------------- config registers ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_field_w  <= '0;
            r_field_h  <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                cpt_pkg::REG_CENTER_X:     r_center_x <= pwdata[cpt_pkg::POS_W-1:0];
                cpt_pkg::REG_CENTER_Y:     r_center_y <= pwdata[cpt_pkg::POS_W-1:0];
                cpt_pkg::REG_FIELD_WIDTH:  r_field_w  <= pwdata[cpt_pkg::FLD_W-1:0];
                cpt_pkg::REG_FIELD_HEIGHT: r_field_h  <= pwdata[cpt_pkg::FLD_W-1:0];
                default: ;
            endcase
        end
    end

    // byte offset bits within a word read back nothing different
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            cpt_pkg::REG_CENTER_X:     prdata = {20'd0, r_center_x};
            cpt_pkg::REG_CENTER_Y:     prdata = {20'd0, r_center_y};
            cpt_pkg::REG_FIELD_WIDTH:  prdata = {19'd0, r_field_w};
            cpt_pkg::REG_FIELD_HEIGHT: prdata = {19'd0, r_field_h};
            default:                   prdata = {30'd0, paddr[1:0]};
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_SQ;
            S_SQ:    n_state = S_CMP;
            S_CMP:   n_state = S_PICK;
            S_PICK:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_PICK);
            if (r_state == S_PICK) begin
                r_count <= n_count;
            end
        end
    end

    // command payload is held for the whole item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
        if (r_state == S_CMP) begin
            r_border_ok <= n_border_ok;
        end
        if (r_state == S_PICK) begin
            r_out <= n_out;
        end
    end

    // strictly inside the field shrunk by the radius
    assign w_cx = 15'(r_center_x);
    assign w_cy = 15'(r_center_y);
    assign w_hw = 15'(r_field_w >> 1);
    assign w_hh = 15'(r_field_h >> 1);
    assign w_r  = 15'(r_in.radius);
    assign w_px = 15'(r_in.pos_x);
    assign w_py = 15'(r_in.pos_y);

    assign n_border_ok = (w_cx - w_hw + w_r < w_px) && (w_cy - w_hh + w_r < w_py) &&
                         (w_px < w_cx + w_hw - w_r) && (w_py < w_cy + w_hh - w_r);

    // ---------------- cell chain ----------------
    assign w_pos.x = r_in.pos_x;
    assign w_pos.y = r_in.pos_y;
    assign w_pos.r = r_in.radius;

    assign w_full = (r_count == CW'(MAX_CIRCLES));
    assign w_any  = w_prior[MAX_CIRCLES];

    // place goes through border, overlap, then capacity
    always_comb begin
        w_store = 1'b0;
        unique case (r_in.command)
            cpt_pkg::CMD_PLACE: w_store = r_border_ok && !w_any && !w_full;
            cpt_pkg::CMD_ADD:   w_store = !w_full;
            default:            w_store = 1'b0;
        endcase
    end

    assign w_ctl.sq_en       = (r_state == S_SQ);
    assign w_ctl.cmp_en      = (r_state == S_CMP);
    assign w_ctl.upd_en      = (r_state == S_PICK);
    assign w_ctl.remove_mode = (r_in.command == cpt_pkg::CMD_REMOVE);
    assign w_ctl.store       = w_store;
    assign w_ctl.shift       = (r_in.command == cpt_pkg::CMD_REMOVE);

    // no hit ahead of the first cell
    assign w_prior[0] = 1'b0;

    for (genvar g = 0; g < MAX_CIRCLES; g++) begin : g_cell
        cpt_pkg::t_circle w_next;
        if (g == MAX_CIRCLES - 1) begin : g_last
            // the freed tail slot keeps its old contents, it is past the count
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end

        cpt_cell #(
            .IDX   (g),
            .CNT_B (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_count (r_count),
            .i_next  (w_next),
            .i_prior (w_prior[g]),
            .o_data  (w_data[g]),
            .o_prior (w_prior[g+1]),
            .o_first (w_first[g])
        );
    end

    // the first hit is one-hot, so an or over the gated cells picks it
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < MAX_CIRCLES; i++) begin
            w_hit = w_hit | (w_first[i] ? w_data[i] : '0);
        end
    end

    // ---------------- result ----------------
    always_comb begin
        n_count              = r_count;
        n_out.status         = cpt_pkg::STAT_MISS;
        n_out.removed_x      = '0;
        n_out.removed_y      = '0;
        n_out.removed_radius = '0;
        unique case (r_in.command)
            cpt_pkg::CMD_PLACE: begin
                priority if (!r_border_ok) begin
                    n_out.status = cpt_pkg::STAT_BORDER;
                end else if (w_any) begin
                    n_out.status = cpt_pkg::STAT_OVERLAP;
                end else if (w_full) begin
                    n_out.status = cpt_pkg::STAT_FULL;
                end else begin
                    n_out.status = cpt_pkg::STAT_PLACED;
                    n_count      = r_count + CW'(1);
                end
            end
            cpt_pkg::CMD_ADD: begin
                if (w_full) begin
                    n_out.status = cpt_pkg::STAT_FULL;
                end else begin
                    n_out.status = cpt_pkg::STAT_PLACED;
                    n_count      = r_count + CW'(1);
                end
            end
            cpt_pkg::CMD_REMOVE: begin
                if (w_any) begin
                    n_out.status         = cpt_pkg::STAT_REMOVED;
                    n_out.removed_x      = w_hit.x;
                    n_out.removed_y      = w_hit.y;
                    n_out.removed_radius = w_hit.r;
                    n_count              = r_count - CW'(1);
                end
            end
            default: ;
        endcase
        w_cnt_ext          = {7'd0, n_count};
        n_out.stored_count = w_cnt_ext[6:0];
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    // ---------------- checks ----------------
    `CPT_ASSERT_ALWAYS(a_count_in_range, r_count <= CW'(MAX_CIRCLES), "count beyond table size")
    `CPT_ASSERT_NEXT(a_pick_gives_result, r_state == S_PICK, o_done && !busy, "result not shown after pick")
    `CPT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !o_done, "accepted command did not start")
    `CPT_ASSERT_NEXT(a_remove_shrinks, (r_state == S_PICK) && w_ctl.remove_mode && w_any, r_count == $past(r_count) - CW'(1), "remove did not shrink the table")

endmodule
